// ----- rtl/flptw_pkg.sv -----
// Shared codes for the four-level page table walker: operation, result kind, status,
// page size and walk level codes, entry flag bit positions, widths. No dependencies.
`default_nettype none

package flptw_pkg;

    // operation codes of the input channel
    localparam logic OP_START = 1'b0;
    localparam logic OP_ENTRY = 1'b1;

    // result kinds
    localparam logic KIND_READ   = 1'b0;
    localparam logic KIND_FINISH = 1'b1;

    // finish status
    localparam logic [1:0] ST_OK          = 2'd0;
    localparam logic [1:0] ST_NOT_PRESENT = 2'd1;
    localparam logic [1:0] ST_WRITE_DENY  = 2'd2;

    // page size codes
    localparam logic [1:0] PS_4K = 2'd0;
    localparam logic [1:0] PS_2M = 2'd1;
    localparam logic [1:0] PS_1G = 2'd2;

    // walk levels
    localparam logic [1:0] LVL_PML4 = 2'd0;
    localparam logic [1:0] LVL_PDPT = 2'd1;
    localparam logic [1:0] LVL_PD   = 2'd2;
    localparam logic [1:0] LVL_PT   = 2'd3;

    // entry flag bits
    localparam int BIT_PRESENT  = 0;
    localparam int BIT_WRITE    = 1;
    localparam int BIT_PAGESIZE = 7;

    // internal linear address width, the widest virtual address supported
    localparam int VA_FULL_BITS = 48;
    typedef logic [VA_FULL_BITS-1:0] t_va_full;

    // room to the page end never exceeds one gigabyte, so it fits in 31 bits
    localparam int ROOM_BITS = 31;

endpackage

`default_nettype wire

// ----- rtl/four_level_page_table_walker.sv -----
// Four-level page table walker: walk state registers, single-pass decode of each
// start or returned entry, result register with a skid stage.
// Depends on flptw_pkg for codes and flag bit positions.
//
//  channel | valid   | stall   | payload
//  --------+---------+---------+--------------------------------------------
//  input   | i_valid | o_stall | operation, virtual_address, root_table,
//          |         |         | write_intent, byte_count, entry_data
//  output  | o_valid | i_stall | result_kind, read_address, status,
//          |         |         | physical_address, page_size,
//          |         |         | leaf_entry_low, reachable_bytes
//
// One item is taken per cycle while o_stall is low; its result is registered
// in the output register unless the output stalls. The rate is set by the single
// decode path from the walk state to the result register. Reset is synchronous
// and clears the walk state and both valid flags. A stalled result moves into
// the skid stage and o_stall rises only while the skid stage is full.
`default_nettype none

module four_level_page_table_walker #(
    parameter int PHYS_ADDR_BITS = 52,
    parameter int VIRT_ADDR_BITS = 48
) (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        i_valid,
    output logic                       o_stall,
    input  wire                        i_operation,
    input  wire [VIRT_ADDR_BITS-1:0]   i_virtual_address,
    input  wire [PHYS_ADDR_BITS-1:0]   i_root_table,
    input  wire                        i_write_intent,
    input  wire [31:0]                 i_byte_count,
    input  wire [63:0]                 i_entry_data,
    output logic                       o_valid,
    input  wire                        i_stall,
    output logic                       o_result_kind,
    output logic [PHYS_ADDR_BITS-1:0]  o_read_address,
    output logic [1:0]                 o_status,
    output logic [PHYS_ADDR_BITS-1:0]  o_physical_address,
    output logic [1:0]                 o_page_size,
    output logic [31:0]                o_leaf_entry_low,
    output logic [31:0]                o_reachable_bytes
);

    localparam int RB = flptw_pkg::ROOM_BITS;

    typedef struct packed {
        logic                      kind;
        logic [PHYS_ADDR_BITS-1:0] read_address;
        logic [1:0]                status;
        logic [PHYS_ADDR_BITS-1:0] physical_address;
        logic [1:0]                page_size;
        logic [31:0]               leaf_low;
        logic [31:0]               bytes;
    } t_result;

    // walk state
    logic                  r_busy, n_busy;
    logic [1:0]            r_level, n_level;
    flptw_pkg::t_va_full   r_va, n_va;
    logic                  r_wi, n_wi;
    logic [31:0]           r_bc, n_bc;

    // output register and skid stage
    logic    r_out_valid, r_skid_valid;
    t_result r_out, r_skid;

    logic    in_take, out_take, out_free, has_result;
    t_result res;

    // request path
    logic [1:0]                req_level;
    logic [PHYS_ADDR_BITS-13:0] req_frame;
    logic [8:0]                req_index;

    // leaf path
    logic [1:0]                leaf_size;
    logic [PHYS_ADDR_BITS-1:0] leaf_phys;
    logic [RB-1:0]             leaf_offset;
    logic [RB-1:0]             leaf_room;
    logic [31:0]               leaf_bytes;
    logic                      is_leaf;

    assign o_stall  = r_skid_valid;
    assign in_take  = i_valid && !r_skid_valid;
    assign out_take = r_out_valid && !i_stall;
    assign out_free = !r_out_valid || out_take;

    // table index for the level about to be read
    always_comb begin
        unique case (req_level)
            flptw_pkg::LVL_PML4: req_index = n_va[47:39];
            flptw_pkg::LVL_PDPT: req_index = n_va[38:30];
            flptw_pkg::LVL_PD:   req_index = n_va[29:21];
            flptw_pkg::LVL_PT:   req_index = n_va[20:12];
            default:             req_index = n_va[47:39];
        endcase
    end

    // leaf frame and offset by page size; frame and offset never overlap
    always_comb begin
        unique case (leaf_size)
            flptw_pkg::PS_1G: begin
                leaf_phys   = {i_entry_data[PHYS_ADDR_BITS-1:30], r_va[29:0]};
                leaf_offset = RB'(r_va[29:0]);
                leaf_room   = RB'(31'h4000_0000) - leaf_offset;
            end
            flptw_pkg::PS_2M: begin
                leaf_phys   = {i_entry_data[PHYS_ADDR_BITS-1:21], r_va[20:0]};
                leaf_offset = RB'(r_va[20:0]);
                leaf_room   = RB'(31'h0020_0000) - leaf_offset;
            end
            default: begin
                leaf_phys   = {i_entry_data[PHYS_ADDR_BITS-1:12], r_va[11:0]};
                leaf_offset = RB'(r_va[11:0]);
                leaf_room   = RB'(31'h0000_1000) - leaf_offset;
            end
        endcase
        leaf_bytes = (r_bc < {1'b0, leaf_room}) ? r_bc : {1'b0, leaf_room};
    end

    always_comb begin
        n_busy     = r_busy;
        n_level    = r_level;
        n_va       = r_va;
        n_wi       = r_wi;
        n_bc       = r_bc;
        has_result = 1'b0;
        req_level  = flptw_pkg::LVL_PML4;
        req_frame  = i_root_table[PHYS_ADDR_BITS-1:12];
        leaf_size  = flptw_pkg::PS_4K;
        is_leaf    = 1'b0;
        res        = '0;

        if (r_level == flptw_pkg::LVL_PDPT && i_entry_data[flptw_pkg::BIT_PAGESIZE]) begin
            leaf_size = flptw_pkg::PS_1G;
            is_leaf   = 1'b1;
        end else if (r_level == flptw_pkg::LVL_PD
                     && i_entry_data[flptw_pkg::BIT_PAGESIZE]) begin
            leaf_size = flptw_pkg::PS_2M;
            is_leaf   = 1'b1;
        end else if (r_level == flptw_pkg::LVL_PT) begin
            is_leaf   = 1'b1;
        end

        if (in_take) begin
            if (i_operation == flptw_pkg::OP_START) begin
                if (!r_busy) begin
                    n_busy     = 1'b1;
                    n_level    = flptw_pkg::LVL_PML4;
                    n_va       = flptw_pkg::t_va_full'(i_virtual_address);
                    n_wi       = i_write_intent;
                    n_bc       = i_byte_count;
                    has_result = 1'b1;
                    res.kind   = flptw_pkg::KIND_READ;
                    res.read_address = {req_frame, req_index, 3'b000};
                end
            end else if (r_busy) begin
                has_result = 1'b1;
                if (!i_entry_data[flptw_pkg::BIT_PRESENT]) begin
                    n_busy     = 1'b0;
                    n_level    = flptw_pkg::LVL_PML4;
                    res.kind   = flptw_pkg::KIND_FINISH;
                    res.status = flptw_pkg::ST_NOT_PRESENT;
                end else if (is_leaf) begin
                    n_busy        = 1'b0;
                    n_level       = flptw_pkg::LVL_PML4;
                    res.kind      = flptw_pkg::KIND_FINISH;
                    res.page_size = leaf_size;
                    res.leaf_low  = i_entry_data[31:0];
                    if (r_wi && !i_entry_data[flptw_pkg::BIT_WRITE]) begin
                        res.status = flptw_pkg::ST_WRITE_DENY;
                    end else begin
                        res.status           = flptw_pkg::ST_OK;
                        res.physical_address = leaf_phys;
                        res.bytes            = leaf_bytes;
                    end
                end else begin
                    // table pointer: descend and request the next entry
                    req_level        = r_level + 2'd1;
                    req_frame        = i_entry_data[PHYS_ADDR_BITS-1:12];
                    n_level          = req_level;
                    res.kind         = flptw_pkg::KIND_READ;
                    res.read_address = {req_frame, req_index, 3'b000};
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy       <= 1'b0;
            r_level      <= flptw_pkg::LVL_PML4;
            r_va         <= '0;
            r_wi         <= 1'b0;
            r_bc         <= '0;
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_busy  <= n_busy;
            r_level <= n_level;
            r_va    <= n_va;
            r_wi    <= n_wi;
            r_bc    <= n_bc;

            if (out_free) begin
                // drain the skid stage first, else load the fresh result
                r_out_valid <= r_skid_valid || has_result;
            end
            if (out_free && r_skid_valid) begin
                r_skid_valid <= 1'b0;
            end else if (has_result && !out_free) begin
                r_skid_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            r_out <= r_skid_valid ? r_skid : res;
        end
        if (has_result && !out_free) begin
            r_skid <= res;
        end
    end

    assign o_valid            = r_out_valid;
    assign o_result_kind      = r_out.kind;
    assign o_read_address     = r_out.read_address;
    assign o_status           = r_out.status;
    assign o_physical_address = r_out.physical_address;
    assign o_page_size        = r_out.page_size;
    assign o_leaf_entry_low   = r_out.leaf_low;
    assign o_reachable_bytes  = r_out.bytes;

endmodule

`default_nettype wire
